// ===== hw/rtl/rtttl_pkg.sv =====
// Package for the RTTTL note token parser: phase codes, character codes,
// result type and the small decode functions. No dependencies.
`default_nettype none

package rtttl_pkg;

    localparam int CharW   = 8;
    localparam int DurW    = 6;
    localparam int OctW    = 3;
    localparam int PitchW  = 6;
    localparam int NoteW   = 4;
    localparam int DigitW  = 4;
    localparam int PhaseW  = 3;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 6;

    localparam logic [PhaseW-1:0] PH_NUMBER = 3'd0;
    localparam logic [PhaseW-1:0] PH_SHARP  = 3'd1;
    localparam logic [PhaseW-1:0] PH_DOT    = 3'd2;
    localparam logic [PhaseW-1:0] PH_OCTAVE = 3'd3;
    localparam logic [PhaseW-1:0] PH_DONE   = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_DEFAULT_DURATION = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_DEFAULT_OCTAVE   = 1'd1;

    localparam logic [DurW-1:0] DEFAULT_DURATION_RESET = 6'd4;
    localparam logic [OctW-1:0] DEFAULT_OCTAVE_RESET   = 3'd6;

    localparam logic [CharW-1:0] CHAR_SHARP = 8'h23;
    localparam logic [CharW-1:0] CHAR_DOT   = 8'h2e;
    localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

    localparam logic [DurW-1:0]  SAT_NUMBER = 6'd63;
    localparam logic [6:0]       TOP_PITCH  = 7'd60;
    localparam logic [DigitW-1:0] OCT_LOW   = 4'd4;
    localparam logic [DigitW-1:0] OCT_HIGH  = 4'd8;

    typedef struct packed {
        logic [PitchW-1:0] pitch_index;
        logic [DurW-1:0]   duration_units;
        logic              octave_error;
    } result_t;

    function automatic logic [NoteW-1:0] letter_note(input logic [CharW-1:0] c);
        logic [NoteW-1:0] n;
        unique case (c)
            8'h63:   n = 4'd1;
            8'h64:   n = 4'd3;
            8'h65:   n = 4'd5;
            8'h66:   n = 4'd6;
            8'h67:   n = 4'd8;
            8'h61:   n = 4'd10;
            8'h62:   n = 4'd12;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [DurW-1:0] units_of(input logic [DurW-1:0] den);
        logic [DurW-1:0] u;
        unique case (den)
            6'd32:   u = 6'd1;
            6'd16:   u = 6'd2;
            6'd8:    u = 6'd4;
            6'd4:    u = 6'd8;
            6'd2:    u = 6'd16;
            6'd1:    u = 6'd32;
            default: u = 6'd0;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtttl_if.sv =====
// Valid/ready channel interfaces for the RTTTL note token parser.
// Depends on rtttl_pkg for field widths.
`default_nettype none

interface rtttl_in_if;
    logic                           valid;
    logic                           ready;
    logic [rtttl_pkg::CharW-1:0]    char_code;
    logic                           last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rtttl_out_if;
    logic                           valid;
    logic                           ready;
    logic [rtttl_pkg::PitchW-1:0]   pitch_index;
    logic [rtttl_pkg::DurW-1:0]     duration_units;
    logic                           octave_error;

    modport source (output valid, output pitch_index, output duration_units,
                    output octave_error, input ready);
    modport sink   (input valid, input pitch_index, input duration_units,
                    input octave_error, output ready);
endinterface

interface rtttl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rtttl_pkg::CfgIdxW-1:0]   index;
    logic [rtttl_pkg::CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtttl_parser.sv =====
// Token parse state and per-character update, with the result decode.
// Depends on rtttl_pkg.
`default_nettype none

module rtttl_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step_en,
    input  wire logic [rtttl_pkg::CharW-1:0]    char_code,
    input  wire logic                           last_char,
    input  wire logic [rtttl_pkg::DurW-1:0]     default_duration,
    input  wire logic [rtttl_pkg::OctW-1:0]     default_octave,
    output rtttl_pkg::result_t                  result
);

    logic [rtttl_pkg::PhaseW-1:0] phase_reg, phase_next;
    logic [rtttl_pkg::DurW-1:0]   acc_reg, acc_next;
    logic [rtttl_pkg::NoteW-1:0]  note_reg, note_next;
    logic                         dot_reg, dot_next;
    logic [rtttl_pkg::DigitW-1:0] oct_reg, oct_next;
    logic                         given_reg, given_next;

    logic [rtttl_pkg::PhaseW-1:0] ph;
    logic                         is_digit;
    logic                         taken;
    logic [rtttl_pkg::DigitW-1:0] digit;
    logic [9:0]                   acc_sum;
    logic [rtttl_pkg::DurW-1:0]   den;
    logic [rtttl_pkg::DurW-1:0]   units;
    logic [rtttl_pkg::DigitW-1:0] oct;
    logic [6:0]                   idx;

    assign is_digit = (char_code >= rtttl_pkg::CHAR_ZERO) && (char_code <= rtttl_pkg::CHAR_NINE);
    assign digit    = 4'(char_code - rtttl_pkg::CHAR_ZERO);
    assign acc_sum  = {4'd0, acc_reg} * 10'd10 + {6'd0, digit};

    // Phases after the letter fall through within one character, as a
    // mark that is absent does not consume the character.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        note_next  = note_reg;
        dot_next   = dot_reg;
        oct_next   = oct_reg;
        given_next = given_reg;
        ph         = phase_reg;
        taken      = 1'b0;
        if (phase_reg == rtttl_pkg::PH_NUMBER)
        begin
            if (is_digit)
            begin
                acc_next = (acc_sum > {4'd0, rtttl_pkg::SAT_NUMBER}) ?
                           rtttl_pkg::SAT_NUMBER : acc_sum[rtttl_pkg::DurW-1:0];
            end
            else
            begin
                note_next  = rtttl_pkg::letter_note(char_code);
                phase_next = rtttl_pkg::PH_SHARP;
            end
        end
        else
        begin
            if (ph == rtttl_pkg::PH_SHARP)
            begin
                if (char_code == rtttl_pkg::CHAR_SHARP)
                begin
                    if (note_reg != '0)
                    begin
                        note_next = note_reg + 4'd1;
                    end
                    phase_next = rtttl_pkg::PH_DOT;
                    taken      = 1'b1;
                end
                ph = rtttl_pkg::PH_DOT;
            end
            if (!taken && ph == rtttl_pkg::PH_DOT)
            begin
                if (char_code == rtttl_pkg::CHAR_DOT)
                begin
                    dot_next   = 1'b1;
                    phase_next = rtttl_pkg::PH_OCTAVE;
                    taken      = 1'b1;
                end
                ph = rtttl_pkg::PH_OCTAVE;
            end
            if (!taken && ph == rtttl_pkg::PH_OCTAVE)
            begin
                if (is_digit)
                begin
                    oct_next   = digit;
                    given_next = 1'b1;
                end
                phase_next = rtttl_pkg::PH_DONE;
            end
        end
    end

    always_comb
    begin
        den   = (acc_next != '0) ? acc_next : default_duration;
        units = rtttl_pkg::units_of(den);
        oct   = given_next ? oct_next : {1'b0, default_octave};
        idx   = ({3'd0, oct} - 7'd4) * 7'd12 + {3'd0, note_next};
        result.pitch_index    = '0;
        result.octave_error   = 1'b0;
        result.duration_units = dot_next ? units + (units >> 1) : units;
        if (note_next != '0)
        begin
            if (oct < rtttl_pkg::OCT_LOW || oct > rtttl_pkg::OCT_HIGH || idx > rtttl_pkg::TOP_PITCH)
            begin
                result.octave_error = 1'b1;
            end
            else
            begin
                result.pitch_index = idx[rtttl_pkg::PitchW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rtttl_pkg::PH_NUMBER;
            acc_reg   <= '0;
            note_reg  <= '0;
            dot_reg   <= 1'b0;
            oct_reg   <= '0;
            given_reg <= 1'b0;
        end
        else if (step_en)
        begin
            if (last_char)
            begin
                phase_reg <= rtttl_pkg::PH_NUMBER;
                acc_reg   <= '0;
                note_reg  <= '0;
                dot_reg   <= 1'b0;
                oct_reg   <= '0;
                given_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                note_reg  <= note_next;
                dot_reg   <= dot_next;
                oct_reg   <= oct_next;
                given_reg <= given_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rtttl_note_token_parser_top.sv =====
// Top level of the RTTTL note token parser: input register, result register
// and configuration registers. Depends on rtttl_pkg, rtttl_if and rtttl_parser.
// An accepted item is held in the input register, and a token's result is then stored in the result register.
// Throughput: one item per cycle; an item that ends a token waits only for a
// free result register, which clears when the consumer takes the result.
// Reset clears the token state and loads default duration 4 and octave 6.
`default_nettype none

module rtttl_note_token_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rtttl_in_if.sink        item_in,
    rtttl_out_if.source     item_out,
    rtttl_cfg_if.sink       cfg
);

    logic [rtttl_pkg::DurW-1:0]   def_dur_reg;
    logic [rtttl_pkg::OctW-1:0]   def_oct_reg;

    logic                         s1_valid_reg, s1_valid_next;
    logic [rtttl_pkg::CharW-1:0]  s1_char_reg;
    logic                         s1_last_reg;

    logic                         out_valid_reg, out_valid_next;
    rtttl_pkg::result_t           out_reg;
    rtttl_pkg::result_t           step_result;

    logic                         out_free;
    logic                         s1_go;
    logic                         in_fire;
    logic                         out_load;

    assign out_free = !out_valid_reg || item_out.ready;
    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign out_load = s1_go && s1_last_reg;
    assign item_in.ready = !s1_valid_reg || s1_go;
    assign in_fire  = item_in.valid && item_in.ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (item_out.ready ? 1'b0 : out_valid_reg);

    assign cfg.ready = 1'b1;

    assign item_out.valid          = out_valid_reg;
    assign item_out.pitch_index    = out_reg.pitch_index;
    assign item_out.duration_units = out_reg.duration_units;
    assign item_out.octave_error   = out_reg.octave_error;

    rtttl_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (s1_go),
        .char_code        (s1_char_reg),
        .last_char        (s1_last_reg),
        .default_duration (def_dur_reg),
        .default_octave   (def_oct_reg),
        .result           (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_dur_reg <= rtttl_pkg::DEFAULT_DURATION_RESET;
            def_oct_reg <= rtttl_pkg::DEFAULT_OCTAVE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rtttl_pkg::REG_DEFAULT_DURATION: def_dur_reg <= cfg.data;
                rtttl_pkg::REG_DEFAULT_OCTAVE:   def_oct_reg <= cfg.data[rtttl_pkg::OctW-1:0];
                default:                         def_dur_reg <= def_dur_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= item_in.char_code;
            s1_last_reg <= item_in.last_char;
        end
        if (out_load)
        begin
            out_reg <= step_result;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the RTTTL note token parser top level.
// Depends on rtttl_pkg and the channel interfaces in rtttl_if; the parser's
// behavior is predicted here and every result item is compared field by field.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtttl_pkg::*;

    typedef logic [CharW-1:0] char_t;

    localparam int RUN_LIMIT = 200000;
    localparam int LONG_STALL = 300;
    localparam logic [8*8-1:0] NOTE_LETTERS = "cdefgabp";

    logic clk = 1'b0;
    logic rst_n;

    rtttl_in_if  in_ch();
    rtttl_out_if out_ch();
    rtttl_cfg_if cfg_ch();

    rtttl_note_token_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_ch),
        .item_out (out_ch),
        .cfg      (cfg_ch)
    );

    logic [PhaseW-1:0] tok_phase;
    logic [DurW-1:0]   tok_number;
    logic [NoteW-1:0]  tok_note;
    logic              tok_dotted;
    logic [DigitW-1:0] tok_octave;
    logic              tok_octave_set;
    logic [DurW-1:0]   dflt_duration;
    logic [OctW-1:0]   dflt_octave;

    result_t pending_notes[$];
    result_t expected_note;
    int fail_count = 0;
    int cycle_count = 0;
    int chars_sent = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_requests = 0;
    int stall_seen = 0;
    int stall_left = 0;

    always #5 clk = ~clk;

    function automatic logic [NoteW-1:0] note_of_letter(input char_t c);
        case (c)
            "c":     return 4'd1;
            "d":     return 4'd3;
            "e":     return 4'd5;
            "f":     return 4'd6;
            "g":     return 4'd8;
            "a":     return 4'd10;
            "b":     return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [DurW-1:0] units_for_denominator(input logic [DurW-1:0] den);
        if (den != 0 && (den & (den - 1)) == 0 && den <= 32)
            return DurW'(32 / den);
        return '0;
    endfunction

    function automatic void clear_token_state();
        tok_phase = PH_NUMBER;
        tok_number = '0;
        tok_note = '0;
        tok_dotted = 1'b0;
        tok_octave = '0;
        tok_octave_set = 1'b0;
    endfunction

    function automatic void parse_note_char(input char_t c, input logic last);
        int acc;
        int oct;
        int idx;
        logic is_num;
        logic consumed;
        logic [DurW-1:0] units;
        result_t note;
        is_num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        consumed = 1'b0;
        if (tok_phase == PH_NUMBER)
        begin
            if (is_num)
            begin
                acc = int'(tok_number) * 10 + int'(c - CHAR_ZERO);
                tok_number = (acc > int'(SAT_NUMBER)) ? SAT_NUMBER : DurW'(acc);
            end
            else
            begin
                tok_note = note_of_letter(c);
                tok_phase = PH_SHARP;
            end
        end
        else
        begin
            if (tok_phase == PH_SHARP)
            begin
                if (c == CHAR_SHARP)
                begin
                    if (tok_note != 0)
                        tok_note = tok_note + 1'b1;
                    consumed = 1'b1;
                end
                tok_phase = PH_DOT;
            end
            if (tok_phase == PH_DOT && !consumed)
            begin
                if (c == CHAR_DOT)
                begin
                    tok_dotted = 1'b1;
                    consumed = 1'b1;
                end
                tok_phase = PH_OCTAVE;
            end
            if (tok_phase == PH_OCTAVE && !consumed)
            begin
                if (is_num)
                begin
                    tok_octave = DigitW'(c - CHAR_ZERO);
                    tok_octave_set = 1'b1;
                end
                tok_phase = PH_DONE;
            end
        end
        if (!last)
            return;
        units = units_for_denominator((tok_number != 0) ? tok_number : dflt_duration);
        if (tok_dotted)
            units = units + (units >> 1);
        note.pitch_index = '0;
        note.duration_units = units;
        note.octave_error = 1'b0;
        if (tok_note != 0)
        begin
            oct = tok_octave_set ? int'(tok_octave) : int'(dflt_octave);
            idx = (oct - 4) * 12 + int'(tok_note);
            if (oct < int'(OCT_LOW) || oct > int'(OCT_HIGH) || idx > int'(TOP_PITCH))
                note.octave_error = 1'b1;
            else
                note.pitch_index = PitchW'(idx);
        end
        pending_notes = {pending_notes, note};
        clear_token_state();
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dflt_duration = DEFAULT_DURATION_RESET;
            dflt_octave = DEFAULT_OCTAVE_RESET;
            clear_token_state();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == REG_DEFAULT_DURATION)
                    dflt_duration = cfg_ch.data[DurW-1:0];
                else if (cfg_ch.index == REG_DEFAULT_OCTAVE)
                    dflt_octave = cfg_ch.data[OctW-1:0];
            end
            if (in_ch.valid && in_ch.ready)
                parse_note_char(in_ch.char_code, in_ch.last_char);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_notes.size() == 0)
                begin
                    $error("unexpected result item: pitch_index %0d duration_units %0d octave_error %0d",
                           out_ch.pitch_index, out_ch.duration_units, out_ch.octave_error);
                    fail_count++;
                end
                else
                begin
                    expected_note = pending_notes.pop_front();
                    if (out_ch.pitch_index !== expected_note.pitch_index)
                    begin
                        $error("pitch_index: expected %0d, got %0d",
                               expected_note.pitch_index, out_ch.pitch_index);
                        fail_count++;
                    end
                    if (out_ch.duration_units !== expected_note.duration_units)
                    begin
                        $error("duration_units: expected %0d, got %0d",
                               expected_note.duration_units, out_ch.duration_units);
                        fail_count++;
                    end
                    if (out_ch.octave_error !== expected_note.octave_error)
                    begin
                        $error("octave_error: expected %0d, got %0d",
                               expected_note.octave_error, out_ch.octave_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_requests != stall_seen)
        begin
            stall_seen <= stall_requests;
            stall_left <= LONG_STALL;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_char(input char_t c, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_code <= c;
        in_ch.last_char <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_random_token();
        char_t tok[$];
        string num;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(4, 1))
                tok = {tok, char_t'($urandom_range(255))};
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                num = $sformatf("%0d", 1 << $urandom_range(5));
            else if (pick < 60)
                num = $sformatf("%0d", $urandom_range(99));
            else if (pick < 70)
                num = $sformatf("%0d", $urandom_range(9999, 100));
            else
                num = "";
            for (int i = 0; i < num.len(); i++)
                tok = {tok, char_t'(num[i])};
            pick = $urandom_range(99);
            if (pick < 80)
                tok = {tok, char_t'(NOTE_LETTERS[8 * $urandom_range(7) +: 8])};
            else if (pick < 90)
                tok = {tok, char_t'($urandom_range("Z", "A"))};
            else
                tok = {tok, char_t'($urandom_range(255))};
            if ($urandom_range(99) < 35)
                tok = {tok, CHAR_SHARP};
            if ($urandom_range(99) < 25)
                tok = {tok, CHAR_DOT};
            pick = $urandom_range(99);
            if (pick < 55)
                tok = {tok, char_t'(CHAR_ZERO + $urandom_range(8, 4))};
            else if (pick < 70)
                tok = {tok, char_t'(CHAR_ZERO + $urandom_range(9))};
            if ($urandom_range(99) < 10)
                tok = {tok, char_t'($urandom_range(255))};
            if ($urandom_range(99) < 10)
            begin
                repeat ($urandom_range(tok.size() - 1))
                    void'(tok.pop_back());
            end
        end
        for (int i = 0; i < tok.size(); i++)
            send_char(tok[i], i == tok.size() - 1);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at)
            send_random_token();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_notes.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_defaults(input logic [DurW-1:0] dur, input logic [OctW-1:0] oct);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_DEFAULT_DURATION;
        cfg_ch.data <= CfgDataW'(dur);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= REG_DEFAULT_OCTAVE;
        cfg_ch.data <= CfgDataW'(oct);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_text("c");
        // A token of digits only ends as a rest.
        send_text("8");
        // The number saturates and no longer names a valid length.
        send_text("99c");
        send_text("p#");
        send_text("c9");
        // A sharp b in the top octave falls off the scale.
        send_text("b#8");
        // The trailing dot after the octave is ignored.
        send_text("1c.5.");
        send_text("C");
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        send_text("0g");
        send_text("32e.");
        wait_drained();
    endtask

    task automatic test_register_settings();
        tx_idle_pct = 27;
        rx_idle_pct <= 67;
        write_defaults(6'd1, 3'd4);
        run_random(60);
        wait_drained();
        write_defaults(6'd32, 3'd7);
        run_random(60);
        wait_drained();
        write_defaults(6'd0, 3'd0);
        run_random(60);
        wait_drained();
        write_defaults(6'd63, 3'd3);
        run_random(60);
        wait_drained();
        write_defaults(6'd16, 3'd5);
        run_random(60);
        wait_drained();
        write_defaults(6'd2, 3'd7);
        run_random(60);
        wait_drained();
        write_defaults(6'd8, 3'd4);
        run_random(60);
        wait_drained();
        write_defaults(DEFAULT_DURATION_RESET, DEFAULT_OCTAVE_RESET);
        run_random(60);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        tx_idle_pct = 27;
        rx_idle_pct <= 67;
        run_random(350);
        tx_idle_pct = 67;
        rx_idle_pct <= 27;
        run_random(350);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_random(350);
        wait_drained();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        stall_requests <= stall_requests + 1;
        run_random(250);
        wait_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.char_code <= '0;
        in_ch.last_char <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_DEFAULT_DURATION;
        cfg_ch.data <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_settings();
        test_random_traffic();
        test_output_stall();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rtttl_pkg.sv
hw/rtl/rtttl_if.sv
hw/rtl/rtttl_parser.sv
hw/rtl/rtttl_note_token_parser_top.sv
tb/sv/tb_top.sv
